// ===== sv/cdmr_pkg.sv =====
// Package for the clock digit matrix renderer.
// Holds the queue entry type, the row constants and the 8x16 digit font.
// No dependencies; used by every module of the block but the checker.
package cdmr_pkg;

    localparam int FIFO_DEPTH = 2;

    localparam int ROW_W       = 4;
    localparam int PIX_W       = 32;
    localparam logic [ROW_W-1:0] ROW_LAST = 4'd15;

    // digit column offsets: hour tens, hour units, minute tens, minute units
    localparam int SHIFT_H10 = 1;
    localparam int SHIFT_H1  = 7;
    localparam int SHIFT_M10 = 17;
    localparam int SHIFT_M1  = 24;

    localparam logic [PIX_W-1:0] COLON_BITS = 32'h0001_8000;

    localparam logic [4:0] HOURS_MAX   = 5'd23;
    localparam logic [5:0] MINUTES_MAX = 6'd59;

    // one time value, already split into decimal digits
    typedef struct packed {
        logic [1:0] hour_tens;
        logic [3:0] hour_units;
        logic [2:0] min_tens;
        logic [3:0] min_units;
        logic       colon_on;
    } cdmr_entry_t;

    // queue status seen by the back end
    typedef struct packed {
        logic valid;
        logic full;
    } cdmr_fifo_stat_t;

    localparam logic [7:0] GLYPH_ROM [0:9][0:15] = '{
        '{8'h00,8'h00,8'h00,8'h18,8'h24,8'h42,8'h42,8'h42,
          8'h42,8'h42,8'h42,8'h42,8'h24,8'h18,8'h00,8'h00},
        '{8'h00,8'h00,8'h00,8'h08,8'h0E,8'h08,8'h08,8'h08,
          8'h08,8'h08,8'h08,8'h08,8'h08,8'h3E,8'h00,8'h00},
        '{8'h00,8'h00,8'h00,8'h3C,8'h42,8'h42,8'h42,8'h20,
          8'h20,8'h10,8'h08,8'h04,8'h42,8'h7E,8'h00,8'h00},
        '{8'h00,8'h00,8'h00,8'h3C,8'h42,8'h42,8'h20,8'h18,
          8'h20,8'h40,8'h40,8'h42,8'h22,8'h1C,8'h00,8'h00},
        '{8'h00,8'h00,8'h00,8'h20,8'h30,8'h28,8'h24,8'h24,
          8'h22,8'h22,8'h7E,8'h20,8'h20,8'h78,8'h00,8'h00},
        '{8'h00,8'h00,8'h00,8'h7E,8'h02,8'h02,8'h02,8'h1A,
          8'h26,8'h40,8'h40,8'h42,8'h22,8'h1C,8'h00,8'h00},
        '{8'h00,8'h00,8'h00,8'h38,8'h24,8'h02,8'h02,8'h1A,
          8'h26,8'h42,8'h42,8'h42,8'h24,8'h18,8'h00,8'h00},
        '{8'h00,8'h00,8'h00,8'h7E,8'h22,8'h22,8'h10,8'h10,
          8'h08,8'h08,8'h08,8'h08,8'h08,8'h08,8'h00,8'h00},
        '{8'h00,8'h00,8'h00,8'h3C,8'h42,8'h42,8'h42,8'h24,
          8'h18,8'h24,8'h42,8'h42,8'h42,8'h3C,8'h00,8'h00},
        '{8'h00,8'h00,8'h00,8'h18,8'h24,8'h42,8'h42,8'h42,
          8'h64,8'h58,8'h40,8'h40,8'h24,8'h1C,8'h00,8'h00}
    };

    function automatic logic [7:0] glyph(input logic [3:0] digit, input logic [3:0] row);
        logic [7:0] g;
        g = 8'h00;
        if (digit <= 4'd9) begin
            g = GLYPH_ROM[digit][row];
        end
        return g;
    endfunction

endpackage

// ===== sv/cdmr_front.sv =====
// Front end: takes input items, clamps hours and minutes and splits them
// into decimal digits for the queue. Depends on cdmr_pkg.
module cdmr_front (
    input  logic                 s_tvalid,
    input  logic [4:0]           hours,
    input  logic [5:0]           minutes,
    input  logic                 colon_on,
    input  logic                 fifo_full,
    output logic                 s_tready,
    output logic                 push,
    output cdmr_pkg::cdmr_entry_t push_entry
);

    logic [4:0] hrs;
    logic [5:0] mins;
    logic [1:0] h_tens;
    logic [4:0] h_base;
    logic [2:0] m_tens;
    logic [5:0] m_base;
    logic [4:0] h_units;
    logic [5:0] m_units;

    assign s_tready = !fifo_full;
    assign push     = s_tvalid && !fifo_full;

    always_comb begin
        hrs  = (hours > cdmr_pkg::HOURS_MAX) ? cdmr_pkg::HOURS_MAX : hours;
        mins = (minutes > cdmr_pkg::MINUTES_MAX) ? cdmr_pkg::MINUTES_MAX : minutes;

        if (hrs >= 5'd20) begin
            h_tens = 2'd2; h_base = 5'd20;
        end else if (hrs >= 5'd10) begin
            h_tens = 2'd1; h_base = 5'd10;
        end else begin
            h_tens = 2'd0; h_base = 5'd0;
        end

        if (mins >= 6'd50) begin
            m_tens = 3'd5; m_base = 6'd50;
        end else if (mins >= 6'd40) begin
            m_tens = 3'd4; m_base = 6'd40;
        end else if (mins >= 6'd30) begin
            m_tens = 3'd3; m_base = 6'd30;
        end else if (mins >= 6'd20) begin
            m_tens = 3'd2; m_base = 6'd20;
        end else if (mins >= 6'd10) begin
            m_tens = 3'd1; m_base = 6'd10;
        end else begin
            m_tens = 3'd0; m_base = 6'd0;
        end

        h_units = hrs - h_base;
        m_units = mins - m_base;

        push_entry.hour_tens  = h_tens;
        push_entry.hour_units = h_units[3:0];
        push_entry.min_tens   = m_tens;
        push_entry.min_units  = m_units[3:0];
        push_entry.colon_on   = colon_on;
    end

endmodule

// ===== sv/cdmr_fifo.sv =====
// Short queue of split time values between front and back end.
// Depends on cdmr_pkg for the entry and status types.
module cdmr_fifo #(
    parameter int DEPTH = cdmr_pkg::FIFO_DEPTH
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     push,
    input  cdmr_pkg::cdmr_entry_t    push_entry,
    input  logic                     pop,
    output cdmr_pkg::cdmr_entry_t    pop_entry,
    output cdmr_pkg::cdmr_fifo_stat_t stat
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    cdmr_pkg::cdmr_entry_t mem [DEPTH];

    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign stat.valid = (count_reg != '0);
    assign stat.full  = (count_reg == CNT_FULL);
    assign pop_entry  = mem[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

// ===== sv/cdmr_back.sv =====
// Back end: walks the sixteen rows of the current time value, builds each
// row word from the font and holds it in the output register. Uses cdmr_pkg.
module cdmr_back (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      colour_select,
    input  cdmr_pkg::cdmr_fifo_stat_t fifo_stat,
    input  cdmr_pkg::cdmr_entry_t     pop_entry,
    output logic                      pop,
    input  logic                      m_tready,
    output logic                      m_tvalid,
    output logic [3:0]                row_index,
    output logic [31:0]               red_row,
    output logic [31:0]               green_row,
    output logic                      last_row
);

    cdmr_pkg::cdmr_entry_t cur_reg, cur_next;
    logic                  active_reg, active_next;
    logic [3:0]            row_reg, row_next;
    logic                  out_valid_reg, out_valid_next;
    logic [3:0]            out_row_reg, out_row_next;
    logic [31:0]           out_red_reg, out_red_next;
    logic [31:0]           out_green_reg, out_green_next;
    logic                  out_last_reg, out_last_next;

    logic        emit;
    logic        at_last;
    logic [31:0] word;
    logic [7:0]  g_h10, g_h1, g_m10, g_m1;

    assign emit    = active_reg && (!out_valid_reg || m_tready);
    assign at_last = (row_reg == cdmr_pkg::ROW_LAST);
    // next time value is picked up while idle, or in the same cycle the last row leaves
    assign pop     = fifo_stat.valid && (!active_reg || (emit && at_last));

    always_comb begin
        g_h10 = cdmr_pkg::glyph({2'b00, cur_reg.hour_tens}, row_reg);
        g_h1  = cdmr_pkg::glyph(cur_reg.hour_units, row_reg);
        g_m10 = cdmr_pkg::glyph({1'b0, cur_reg.min_tens}, row_reg);
        g_m1  = cdmr_pkg::glyph(cur_reg.min_units, row_reg);

        word = ({24'd0, g_h1}  << cdmr_pkg::SHIFT_H1)
             | ({24'd0, g_m10} << cdmr_pkg::SHIFT_M10)
             | ({24'd0, g_m1}  << cdmr_pkg::SHIFT_M1);
        // leading zero of the hour is left dark
        if (cur_reg.hour_tens != 2'd0) begin
            word = word | ({24'd0, g_h10} << cdmr_pkg::SHIFT_H10);
        end
        if (cur_reg.colon_on && (row_reg == 4'd5 || row_reg == 4'd6 ||
                                 row_reg == 4'd10 || row_reg == 4'd11)) begin
            word = word | cdmr_pkg::COLON_BITS;
        end
    end

    always_comb begin
        cur_next    = cur_reg;
        active_next = active_reg;
        row_next    = row_reg;
        if (pop) begin
            cur_next    = pop_entry;
            active_next = 1'b1;
            row_next    = '0;
        end else if (emit) begin
            if (at_last) begin
                active_next = 1'b0;
            end
            row_next = row_reg + 1'b1;
        end

        out_valid_next = out_valid_reg;
        out_row_next   = out_row_reg;
        out_red_next   = out_red_reg;
        out_green_next = out_green_reg;
        out_last_next  = out_last_reg;
        if (emit) begin
            out_valid_next = 1'b1;
            out_row_next   = row_reg;
            out_red_next   = colour_select ? 32'd0 : word;
            out_green_next = colour_select ? word : 32'd0;
            out_last_next  = at_last;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_reg    <= 1'b0;
            row_reg       <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            active_reg    <= active_next;
            row_reg       <= row_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        cur_reg       <= cur_next;
        out_row_reg   <= out_row_next;
        out_red_reg   <= out_red_next;
        out_green_reg <= out_green_next;
        out_last_reg  <= out_last_next;
    end

    assign m_tvalid  = out_valid_reg;
    assign row_index = out_row_reg;
    assign red_row   = out_red_reg;
    assign green_row = out_green_reg;
    assign last_row  = out_last_reg;

endmodule

// ===== sv/clock_digit_matrix_renderer.sv =====
// Channel   Dir  Handshake          Payload
// s_axis    in   s_tvalid/s_tready  tdata: hours, minutes, colon_on
// m_axis    out  m_tvalid/m_tready  tdata: row_index, red_row, green_row; tlast: last_row
// cfg       in   cfg_we             cfg_wdata: colour_select
//
// Each time value yields 16 row items, one per cycle while m_tready holds, so in
// steady state an input item is taken once the previous value's rows are out; the back-end row counter sets this pace.
// The first row passes through the queue, the current-value register and the output register.
// Reset (aresetn low, synchronous) empties the queue and the output register
// and sets colour_select to red. Input stalls only when the queue is full;
// output stalls freeze the row counter and leave the queue filling.
// Top level of the clock digit matrix renderer; uses cdmr_pkg, cdmr_front,
// cdmr_fifo and cdmr_back.
module clock_digit_matrix_renderer #(
    parameter int FIFO_DEPTH = cdmr_pkg::FIFO_DEPTH
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [4:0] hours, [10:5] minutes, [11] colon_on, [15:12] zero
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [71:0] m_tdata,   // [3:0] row_index, [35:4] red_row, [67:36] green_row,
                                   // [71:68] zero
    output logic        m_tlast,   // last_row
    input  logic        cfg_we,
    input  logic        cfg_wdata  // colour_select
);

    logic                      colour_select_reg;
    logic                      push;
    logic                      pop;
    cdmr_pkg::cdmr_entry_t     push_entry;
    cdmr_pkg::cdmr_entry_t     pop_entry;
    cdmr_pkg::cdmr_fifo_stat_t fifo_stat;
    logic [3:0]                row_index;
    logic [31:0]               red_row;
    logic [31:0]               green_row;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            colour_select_reg <= 1'b0;
        end else if (cfg_we) begin
            colour_select_reg <= cfg_wdata;
        end
    end

    cdmr_front u_front (
        .s_tvalid   (s_tvalid),
        .hours      (s_tdata[4:0]),
        .minutes    (s_tdata[10:5]),
        .colon_on   (s_tdata[11]),
        .fifo_full  (fifo_stat.full),
        .s_tready   (s_tready),
        .push       (push),
        .push_entry (push_entry)
    );

    cdmr_fifo #(
        .DEPTH (FIFO_DEPTH)
    ) u_fifo (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .pop_entry  (pop_entry),
        .stat       (fifo_stat)
    );

    cdmr_back u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .colour_select (colour_select_reg),
        .fifo_stat     (fifo_stat),
        .pop_entry     (pop_entry),
        .pop           (pop),
        .m_tready      (m_tready),
        .m_tvalid      (m_tvalid),
        .row_index     (row_index),
        .red_row       (red_row),
        .green_row     (green_row),
        .last_row      (m_tlast)
    );

    assign m_tdata = {4'd0, green_row, red_row, row_index};

endmodule

// ===== sv/cdmr_checker.sv =====
// Port-level checks for the clock digit matrix renderer, bound to the top.
// Depends only on the top-level ports.
module cdmr_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic [15:0] s_tdata,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [71:0] m_tdata,
    input logic        m_tlast,
    input logic        cfg_we,
    input logic        cfg_wdata
);

    // output side is empty right after reset
    a_reset_empty: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("output valid after reset");

    // tlast marks exactly the bottom row
    a_last_row: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tlast == (m_tdata[3:0] == 4'hF)))
        else $error("tlast does not match row 15");

    // only one colour word carries the image
    a_one_colour: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[35:4] == 32'd0 || m_tdata[67:36] == 32'd0))
        else $error("both colour words nonzero");

    // rows of a frame follow back to back
    a_row_seq: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tready && !m_tlast) |=>
            (m_tvalid && m_tdata[3:0] == $past(m_tdata[3:0]) + 4'd1))
        else $error("row sequence broken");

endmodule

bind clock_digit_matrix_renderer cdmr_checker u_cdmr_checker (.*);
